>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every user has ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tgcq_pkg.sv
package tgcq_pkg;

   // Bitmap geometry.
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = 6;
   localparam int ROW_W    = 6;

   // Field and register widths.
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 16;
   localparam int SIZE_W     = 9;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = COUNT_W + SIZE_W;
   localparam int WIDE_W     = COORD_W + 2;

   // Divider geometry: nonnegative pixel offsets divided by a tile size.
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic signed [WIDE_W-1:0] ONE_W = 1;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POINT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BOX   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_LEFT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_TOP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS_USED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED    = 3'd5;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/tgcq_ram.sv
module tgcq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/tgcq_div.sv
module tgcq_div
   import tgcq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring divider, one quotient bit per cycle. The dividend shifts out
   // of the top of quo_ff while quotient bits shift in at the bottom.
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [SIZE_W-1:0]    dsr_ff, dsr_in;
   logic [SIZE_W:0]      trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      trial    = {rem_ff, quo_ff[DIV_W-1]};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = req.dividend;
         dsr_in   = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SIZE_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

>>> hw/rtl/tile_grid_collision_query.sv
//  Channel   Ports                               Transfer
//  -------   ---------------------------------   -------------------------------
//  request   start, busy, req_*                  edge with start high, busy low
//  result    rsp_valid, rsp_hit                  edge ending the rsp_valid cycle
//  config    csr_we, csr_index, csr_wdata        edge with csr_we high
//
//  One item is in flight at a time; busy is high from the transfer until the result
//  cycle has ended. A tile write reads its row and writes it back. A point query
//  runs the two 16-step dividers once, a box query twice; a box query then scans
//  its row range (1 to 64 rows) up to a hit, one row per cycle from its read port.
//  Reset is synchronous and clears every tile at once through per-row valid bits,
//  so no clearing pass is needed. The receiver cannot stall the result.
`include "assert_macros.svh"

module tile_grid_collision_query
   import tgcq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [CMD_W-1:0]             req_cmd,
   input  logic [COL_W-1:0]             req_tile_col,
   input  logic [ROW_W-1:0]             req_tile_row,
   input  logic                         req_tile_solid,
   input  logic signed [COORD_W-1:0]    req_left_x,
   input  logic signed [COORD_W-1:0]    req_top_y,
   input  logic signed [COORD_W-1:0]    req_right_x,
   input  logic signed [COORD_W-1:0]    req_bottom_y,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   // Sequencer states.
   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
   localparam logic [STATE_W-1:0] S_WR_MOD = 4'd1;
   localparam logic [STATE_W-1:0] S_PREP   = 4'd2;
   localparam logic [STATE_W-1:0] S_CHECK  = 4'd3;
   localparam logic [STATE_W-1:0] S_DIV0   = 4'd4;
   localparam logic [STATE_W-1:0] S_PT_RD  = 4'd5;
   localparam logic [STATE_W-1:0] S_DIV1   = 4'd6;
   localparam logic [STATE_W-1:0] S_RANGE  = 4'd7;
   localparam logic [STATE_W-1:0] S_MASK   = 4'd8;
   localparam logic [STATE_W-1:0] S_SCAN   = 4'd9;
   localparam logic [STATE_W-1:0] S_RESP   = 4'd10;

   logic [STATE_W-1:0] state_ff, state_in;

   // Configuration registers.
   logic signed [COORD_W-1:0] grid_left_ff, grid_top_ff;
   logic [SIZE_W-1:0]         tile_width_ff, tile_height_ff;
   logic [COUNT_W-1:0]        columns_used_ff, rows_used_ff;

   // One valid bit per bitmap row. A row whose bit is clear reads as all empty,
   // which is how reset clears the whole bitmap at once.
   logic [MAX_ROWS-1:0] valid_ff, valid_in;

   // Captured request.
   logic [CMD_W-1:0]          cmd_ff;
   logic                      solid_ff;
   logic signed [COORD_W-1:0] lx_ff, ty_ff, rx_ff, by_ff;

   // Working registers of the sequencer.
   logic [COL_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]         row_ptr_ff, row_ptr_in;
   logic signed [WIDE_W-1:0] gr_ff, gr_in, gb_ff, gb_in;
   logic                     x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic [DIV_W-1:0]         q0x_ff, q0x_in, q0y_ff, q0y_in;
   logic [DIV_W-1:0]         q1x_ff, q1x_in, q1y_ff, q1y_in;
   logic [COL_W-1:0]         x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic [ROW_W-1:0]         y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   logic [MAX_COLS-1:0]      mask_ff, mask_in;
   logic                     hit_ff, hit_in;

   // Effective configuration: a zero tile size acts as one, and the used counts
   // are clamped to the bitmap.
   logic [SIZE_W-1:0]  tw_eff, th_eff;
   logic [COUNT_W-1:0] cols_eff, rows_eff;
   logic [PROD_W-1:0]  prod_x, prod_y;

   logic signed [WIDE_W-1:0] gl_w, gt_w, lx_w, ty_w, rx_w, by_w;
   logic signed [WIDE_W-1:0] x_diff, y_diff, x_end, y_end;
   logic                     pt_inside, box_inside;
   logic [DIV_W-1:0]         x0c, x1c, y0c, y1c;
   logic                     x_ok, y_ok;
   logic [MAX_COLS-1:0]      mask_calc, row_data, wr_bit, new_row;

   logic                accept;
   logic                div_start;
   div_req_type         x_div_req, y_div_req;
   div_rsp_type         x_div_rsp, y_div_rsp;

   logic                ram_we, ram_re;
   logic [ROW_W-1:0]    ram_addr;
   logic [MAX_COLS-1:0] ram_wdata, ram_rdata;

   assign accept = start && !busy;

   // Configuration writes. Indexes past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_left_ff    <= '0;
         grid_top_ff     <= '0;
         tile_width_ff   <= SIZE_W'(8);
         tile_height_ff  <= SIZE_W'(8);
         columns_used_ff <= COUNT_W'(MAX_COLS);
         rows_used_ff    <= COUNT_W'(MAX_ROWS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_LEFT:    grid_left_ff    <= csr_wdata;
            CSR_GRID_TOP:     grid_top_ff     <= csr_wdata;
            CSR_TILE_WIDTH:   tile_width_ff   <= csr_wdata[SIZE_W-1:0];
            CSR_TILE_HEIGHT:  tile_height_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_COLUMNS_USED: columns_used_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ROWS_USED:    rows_used_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign tw_eff   = (tile_width_ff == '0) ? SIZE_W'(1) : tile_width_ff;
   assign th_eff   = (tile_height_ff == '0) ? SIZE_W'(1) : tile_height_ff;
   assign cols_eff = (columns_used_ff > COUNT_W'(MAX_COLS)) ? COUNT_W'(MAX_COLS)
                                                            : columns_used_ff;
   assign rows_eff = (rows_used_ff > COUNT_W'(MAX_ROWS)) ? COUNT_W'(MAX_ROWS)
                                                         : rows_used_ff;
   assign prod_x   = cols_eff * tw_eff;
   assign prod_y   = rows_eff * th_eff;

   // All coordinate arithmetic runs two bits wider than a pixel so that the
   // grid's far edges and the offsets from its near edges never overflow.
   assign gl_w = WIDE_W'(grid_left_ff);
   assign gt_w = WIDE_W'(grid_top_ff);
   assign lx_w = WIDE_W'(lx_ff);
   assign ty_w = WIDE_W'(ty_ff);
   assign rx_w = WIDE_W'(rx_ff);
   assign by_w = WIDE_W'(by_ff);

   assign x_diff = lx_w - gl_w;
   assign y_diff = ty_w - gt_w;
   assign x_end  = rx_w - gl_w - ONE_W;
   assign y_end  = by_w - gt_w - ONE_W;

   assign pt_inside  = (lx_w >= gl_w) && (ty_w >= gt_w) && (lx_w < gr_ff) && (ty_w < gb_ff);
   assign box_inside = (lx_w < gr_ff) && (rx_w > gl_w) && (ty_w < gb_ff) && (by_w > gt_w);

   // A near edge left of or above the grid clips to tile zero. Once the box
   // overlaps the grid, the far-edge offsets are never negative, so the
   // dividers only ever see nonnegative dividends.
   assign x0c = x_neg_ff ? '0 : q0x_ff;
   assign y0c = y_neg_ff ? '0 : q0y_ff;
   assign x1c = (q1x_ff >= DIV_W'(cols_eff)) ? DIV_W'(cols_eff) - DIV_W'(1) : q1x_ff;
   assign y1c = (q1y_ff >= DIV_W'(rows_eff)) ? DIV_W'(rows_eff) - DIV_W'(1) : q1y_ff;
   assign x_ok = (cols_eff != '0) && (x0c <= x1c);
   assign y_ok = (rows_eff != '0) && (y0c <= y1c);

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         mask_calc[c] = (COL_W'(c) >= x_lo_ff) && (COL_W'(c) <= x_hi_ff);
      end
   end

   // Rows never written since reset read as empty.
   assign row_data = valid_ff[row_ptr_ff] ? ram_rdata : '0;
   assign wr_bit   = MAX_COLS'(1) << col_ff;
   assign new_row  = solid_ff ? (row_data | wr_bit) : (row_data & ~wr_bit);

   // Both dividers run in lockstep: x against the tile width, y against the
   // tile height. The first pass divides the near-edge offsets, the second
   // pass the far-edge offsets of a box.
   assign x_div_req.start    = div_start;
   assign x_div_req.dividend = (state_ff == S_CHECK)
                               ? (x_diff[WIDE_W-1] ? '0 : x_diff[DIV_W-1:0])
                               : x_end[DIV_W-1:0];
   assign x_div_req.divisor  = tw_eff;
   assign y_div_req.start    = div_start;
   assign y_div_req.dividend = (state_ff == S_CHECK)
                               ? (y_diff[WIDE_W-1] ? '0 : y_diff[DIV_W-1:0])
                               : y_end[DIV_W-1:0];
   assign y_div_req.divisor  = th_eff;

   tgcq_div u_x_div (
      .clock (clock),
      .reset (reset),
      .req   (x_div_req),
      .rsp   (x_div_rsp)
   );

   tgcq_div u_y_div (
      .clock (clock),
      .reset (reset),
      .req   (y_div_req),
      .rsp   (y_div_rsp)
   );

   tgcq_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Sequencer. A write reads its row, merges the new bit and writes it back;
   // no other access can come between since only one item is in flight.
   // A box query ends with a scan over its row range, one row read per cycle,
   // that stops early on the first row with a solid tile under the mask.
   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      col_in     = col_ff;
      row_ptr_in = row_ptr_ff;
      gr_in      = gr_ff;
      gb_in      = gb_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      q0x_in     = q0x_ff;
      q0y_in     = q0y_ff;
      q1x_in     = q1x_ff;
      q1y_in     = q1y_ff;
      x_lo_in    = x_lo_ff;
      x_hi_in    = x_hi_ff;
      y_lo_in    = y_lo_ff;
      y_hi_in    = y_hi_ff;
      mask_in    = mask_ff;
      hit_in     = hit_ff;
      div_start  = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_addr   = row_ptr_ff;
      ram_wdata  = new_row;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hit_in     = 1'b0;
               col_in     = req_tile_col;
               row_ptr_in = req_tile_row;
               unique case (req_cmd) inside
                  CMD_WRITE: begin
                     ram_re   = 1'b1;
                     ram_addr = req_tile_row;
                     state_in = S_WR_MOD;
                  end
                  CMD_POINT, CMD_BOX: begin
                     state_in = S_PREP;
                  end
                  CMD_NONE: begin
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_WR_MOD: begin
            ram_we               = 1'b1;
            valid_in[row_ptr_ff] = 1'b1;
            state_in             = S_RESP;
         end
         S_PREP: begin
            gr_in    = gl_w + $signed(WIDE_W'(prod_x));
            gb_in    = gt_w + $signed(WIDE_W'(prod_y));
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((cmd_ff == CMD_POINT) ? pt_inside : box_inside) begin
               div_start = 1'b1;
               x_neg_in  = x_diff[WIDE_W-1];
               y_neg_in  = y_diff[WIDE_W-1];
               state_in  = S_DIV0;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DIV0: begin
            if (x_div_rsp.done) begin
               q0x_in = x_div_rsp.quotient;
               q0y_in = y_div_rsp.quotient;
               col_in = x_div_rsp.quotient[COL_W-1:0];
               if (cmd_ff == CMD_POINT) begin
                  // Inside the grid the tile indexes are below the used counts.
                  ram_re     = 1'b1;
                  ram_addr   = y_div_rsp.quotient[ROW_W-1:0];
                  row_ptr_in = y_div_rsp.quotient[ROW_W-1:0];
                  state_in   = S_PT_RD;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV1;
               end
            end
         end
         S_PT_RD: begin
            hit_in   = row_data[col_ff];
            state_in = S_RESP;
         end
         S_DIV1: begin
            if (x_div_rsp.done) begin
               q1x_in   = x_div_rsp.quotient;
               q1y_in   = y_div_rsp.quotient;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            x_lo_in = x0c[COL_W-1:0];
            x_hi_in = x1c[COL_W-1:0];
            y_lo_in = y0c[ROW_W-1:0];
            y_hi_in = y1c[ROW_W-1:0];
            if (x_ok && y_ok) begin
               state_in = S_MASK;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MASK: begin
            mask_in    = mask_calc;
            ram_re     = 1'b1;
            ram_addr   = y_lo_ff;
            row_ptr_in = y_lo_ff;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if ((row_data & mask_ff) != '0) begin
               hit_in   = 1'b1;
               state_in = S_RESP;
            end else if (row_ptr_ff == y_hi_ff) begin
               state_in = S_RESP;
            end else begin
               ram_re     = 1'b1;
               ram_addr   = row_ptr_ff + ROW_W'(1);
               row_ptr_in = row_ptr_ff + ROW_W'(1);
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         solid_ff <= req_tile_solid;
         lx_ff    <= req_left_x;
         ty_ff    <= req_top_y;
         rx_ff    <= req_right_x;
         by_ff    <= req_bottom_y;
      end
      col_ff     <= col_in;
      row_ptr_ff <= row_ptr_in;
      gr_ff      <= gr_in;
      gb_ff      <= gb_in;
      x_neg_ff   <= x_neg_in;
      y_neg_ff   <= y_neg_in;
      q0x_ff     <= q0x_in;
      q0y_ff     <= q0y_in;
      q1x_ff     <= q1x_in;
      q1y_ff     <= q1y_in;
      x_lo_ff    <= x_lo_in;
      x_hi_ff    <= x_hi_in;
      y_lo_ff    <= y_lo_in;
      y_hi_ff    <= y_hi_in;
      mask_ff    <= mask_in;
      hit_ff     <= hit_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_hit   = hit_ff;

   `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `ASSERT_NEXT(a_resp_done, rsp_valid, !busy, "block still busy after its result")
   `ASSERT_IMPL(a_write_miss, rsp_valid && (cmd_ff == CMD_WRITE), !rsp_hit,
                "tile write reported a hit")
   `ASSERT_IMPL(a_scan_bound, state_ff == S_SCAN, row_ptr_ff <= y_hi_ff,
                "row scan ran past the last row of the range")
   `ASSERT_IMPL(a_div_lockstep, x_div_rsp.done, y_div_rsp.done,
                "x and y dividers finished in different cycles")

endmodule
